[design/bmp_pixel_stream_blitter_core_assert.svh]
// Assertion macros for the BMP pixel stream blitter.
// Used by the top level; expects signals clk and rst in the including scope.
`ifndef BMP_PIXEL_STREAM_BLITTER_CORE_ASSERT_SVH
`define BMP_PIXEL_STREAM_BLITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPSB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpsb: assertion failed");
`define BPSB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bpsb: assertion failed");
`else
`define BPSB_ASSERT(label, prop)
`define BPSB_ASSERT_ALWAYS(label, prop)
`endif
`endif

[design/bpsb_pkg.sv]
// Shared types, constants and helper functions of the BMP pixel stream blitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpsb_pkg;

  localparam int MaxImageDim = 4096;
  localparam int FramebufferBpp = 32;

  localparam int PIXEL_W = 8;
  localparam int DIM_W = 13;
  localparam int HEIGHT_W = 14;
  localparam int COL_W = 12;
  localparam int ROW_W = 13;
  localparam int ORIGIN_W = 12;
  localparam int SHIFTS_W = 20;
  localparam int ADDR_W = 26;
  localparam int WORD_W = FramebufferBpp;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = SHIFTS_W;

  localparam int QueueDepth = 2;
  localparam int QPTR_W = $clog2(QueueDepth);
  localparam int QCNT_W = $clog2(QueueDepth + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_MODE,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_LINE_PITCH,
    REG_CHANNEL_SHIFTS
  } reg_index_t;

  typedef struct packed {
    logic                       depth_mode;
    logic [DIM_W-1:0]           image_width;
    logic signed [HEIGHT_W-1:0] image_height;
    logic [ORIGIN_W-1:0]        x_origin;
    logic [ORIGIN_W-1:0]        y_origin;
    logic [DIM_W-1:0]           line_pitch;
    logic [SHIFTS_W-1:0]        channel_shifts;
  } cfg_t;

  // One finished pixel with the position it belongs to.
  typedef struct packed {
    logic [PIXEL_W-1:0] blue;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] red;
    logic [PIXEL_W-1:0] alpha;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               final_write;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] eff_width(input cfg_t c);
    return (c.image_width > DIM_W'(MaxImageDim)) ? DIM_W'(MaxImageDim) : c.image_width;
  endfunction

  function automatic logic height_negative(input cfg_t c);
    return c.image_height[HEIGHT_W-1];
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input cfg_t c);
    logic [HEIGHT_W-1:0] h;
    logic [HEIGHT_W-1:0] m;
    h = c.image_height;
    m = h[HEIGHT_W-1] ? (HEIGHT_W'(0) - h) : h;
    return (m > HEIGHT_W'(MaxImageDim)) ? DIM_W'(MaxImageDim) : m[DIM_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/bpsb_stream_if.sv]
// Valid/ready channel interfaces for the byte input and the framebuffer writes.
// Depends on bpsb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bpsb_in_if;
  import bpsb_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_byte;
  logic               image_start;
  modport source (output valid, pixel_byte, image_start, input ready);
  modport sink (input valid, pixel_byte, image_start, output ready);
endinterface

interface bpsb_out_if;
  import bpsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [WORD_W-1:0] write_data;
  logic              final_write;
  modport source (output valid, write_address, write_data, final_write, input ready);
  modport sink (input valid, write_address, write_data, final_write, output ready);
endinterface
`default_nettype wire

[design/bpsb_front.sv]
// Front end: takes one byte per beat, tracks pixel, column, row and padding,
// and hands each finished pixel to the queue. Depends on bpsb_pkg, bpsb_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module bpsb_front (
  input  logic              clk,
  input  logic              rst,
  bpsb_in_if.sink           pixels,
  input  bpsb_pkg::cfg_t    cfg,
  input  bpsb_pkg::q_stat_t q_stat,
  output logic              job_push,
  output bpsb_pkg::job_t    job
);
  import bpsb_pkg::*;

  logic [1:0]       byte_position, byte_position_next;
  logic [23:0]      pixel_assembly, pixel_assembly_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [1:0]       padding_left, padding_left_next;
  logic             image_done, image_done_next;

  logic               accept;
  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic [1:0]         last_pos;
  logic [PIXEL_W-1:0] b;
  logic [1:0]         pos0;
  logic [23:0]        asm0;
  logic [COL_W-1:0]   col0;
  logic [ROW_W-1:0]   row0;
  logic [1:0]         pad0;
  logic               done0;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic               fin;

  assign pixels.ready = !q_stat.full;
  assign accept = pixels.valid && pixels.ready;
  assign w = eff_width(cfg);
  assign h = eff_height(cfg);
  assign last_pos = cfg.depth_mode ? 2'd3 : 2'd2;
  assign b = pixels.pixel_byte;

  // A start byte clears the counters before the byte itself is handled.
  always_comb begin
    if (pixels.image_start) begin
      pos0 = '0;
      asm0 = '0;
      col0 = '0;
      row0 = '0;
      pad0 = '0;
      done0 = (w == '0) || (h == '0);
    end else begin
      pos0 = byte_position;
      asm0 = pixel_assembly;
      col0 = column_count;
      row0 = row_count;
      pad0 = padding_left;
      done0 = image_done;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    pixel_assembly_next = pixel_assembly;
    column_count_next = column_count;
    row_count_next = row_count;
    padding_left_next = padding_left;
    image_done_next = image_done;
    job_push = 1'b0;
    fin = 1'b0;
    col_inc = {1'b0, col0} + (COL_W+1)'(1);
    row_inc = {1'b0, row0} + (ROW_W+1)'(1);
    if (accept) begin
      byte_position_next = pos0;
      pixel_assembly_next = asm0;
      column_count_next = col0;
      row_count_next = row0;
      padding_left_next = pad0;
      image_done_next = done0;
      if (!done0) begin
        if (pad0 != 2'd0) begin
          padding_left_next = pad0 - 2'd1;
        end else if (pos0 < last_pos) begin
          case (pos0)
            2'd0: pixel_assembly_next[7:0] = b;
            2'd1: pixel_assembly_next[15:8] = b;
            default: pixel_assembly_next[23:16] = b;
          endcase
          byte_position_next = pos0 + 2'd1;
        end else begin
          job_push = 1'b1;
          byte_position_next = 2'd0;
          if (col_inc >= w) begin
            column_count_next = '0;
            row_count_next = row_inc[ROW_W-1:0];
            if (row_inc >= {1'b0, h}) begin
              fin = 1'b1;
              image_done_next = 1'b1;
            end else begin
              // Rows of 24-bit images pad to four bytes: width mod 4 bytes.
              padding_left_next = cfg.depth_mode ? 2'd0 : w[1:0];
            end
          end else begin
            column_count_next = col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    job.blue = asm0[7:0];
    job.green = asm0[15:8];
    job.red = cfg.depth_mode ? asm0[23:16] : b;
    job.alpha = cfg.depth_mode ? b : '0;
    job.row = row0;
    job.col = col0;
    job.final_write = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pixel_assembly <= '0;
      column_count <= '0;
      row_count <= '0;
      padding_left <= '0;
      image_done <= 1'b1;
    end else begin
      byte_position <= byte_position_next;
      pixel_assembly <= pixel_assembly_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
      padding_left <= padding_left_next;
      image_done <= image_done_next;
    end
  end

endmodule
`default_nettype wire

[design/bpsb_queue.sv]
// Short pixel queue between the front end and the write pipeline.
// Depends on bpsb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpsb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bpsb_pkg::job_t    push_job,
  input  logic              pop,
  output bpsb_pkg::job_t    head,
  output bpsb_pkg::q_stat_t q_stat
);
  import bpsb_pkg::*;

  job_t              entries [QueueDepth];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QueueDepth - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full = (count == QCNT_W'(QueueDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[design/bpsb_back.sv]
// Write pipeline: row and word packing, then the address multiply-add into
// the output register. Depends on bpsb_pkg, bpsb_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module bpsb_back (
  input  logic           clk,
  input  logic           rst,
  input  bpsb_pkg::cfg_t cfg,
  input  bpsb_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  bpsb_out_if.source     writes
);
  import bpsb_pkg::*;

  logic              a_valid;
  logic [ADDR_W-1:0] a_y;
  logic [WORD_W-1:0] a_data;
  logic [COL_W-1:0]  a_col;
  logic              a_final;

  logic              b_advance;
  logic              a_advance;
  logic [ADDR_W-1:0] y_calc;
  logic [WORD_W-1:0] data_calc;
  logic [ADDR_W-1:0] prod;
  logic [ADDR_W-1:0] addr_calc;

  function automatic logic [WORD_W-1:0] place(input logic [PIXEL_W-1:0] v,
                                              input logic [4:0] sh);
    return {(WORD_W-PIXEL_W)'(0), v} << sh;
  endfunction

  assign b_advance = !writes.valid || writes.ready;
  assign a_advance = !a_valid || b_advance;
  assign pop = head_valid && a_advance;

  always_comb begin
    if (height_negative(cfg)) begin
      y_calc = ADDR_W'(cfg.y_origin) + ADDR_W'(head.row);
    end else begin
      y_calc = ADDR_W'(cfg.y_origin) + ADDR_W'(eff_height(cfg)) - ADDR_W'(1)
             - ADDR_W'(head.row);
    end
    data_calc = place(head.alpha, cfg.channel_shifts[19:15])
              | place(head.red, cfg.channel_shifts[14:10])
              | place(head.green, cfg.channel_shifts[9:5])
              | place(head.blue, cfg.channel_shifts[4:0]);
    prod = a_y * ADDR_W'(cfg.line_pitch);
    addr_calc = prod + ADDR_W'(cfg.x_origin) + ADDR_W'(a_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      writes.valid <= 1'b0;
    end else begin
      if (a_advance) begin
        a_valid <= pop;
      end
      if (b_advance) begin
        writes.valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_y <= y_calc;
      a_data <= data_calc;
      a_col <= head.col;
      a_final <= head.final_write;
    end
    if (b_advance && a_valid) begin
      writes.write_address <= addr_calc;
      writes.write_data <= a_data;
      writes.final_write <= a_final;
    end
  end

endmodule
`default_nettype wire

[design/bmp_pixel_stream_blitter_core.sv]
// Top level of the BMP pixel stream blitter: configuration registers, front end,
// pixel queue and write pipeline. Depends on bpsb_pkg, bpsb_stream_if and the
// modules bpsb_front, bpsb_queue, bpsb_back.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_pixel_stream_blitter_core_assert.svh"

// The block takes one byte of BMP pixel data per beat on the pixels channel and
// turns each completed pixel into one framebuffer write beat on the writes
// channel, with the address row * line_pitch + column and the pixel packed by
// the four channel shifts. A beat with image_start set begins a new image and is
// itself the first data byte. Bytes are accepted at one per clock cycle as long
// as the writes side keeps up; the front end handles each byte in the cycle it
// is taken, and the write beat of its last byte goes through the queue entry,
// the row/pack register and then the address multiply-add into the output
// register. A two-entry queue lets bytes keep flowing while the output waits,
// and input ready drops only when that queue is full.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, and should be changed only while no write is outstanding.
module bmp_pixel_stream_blitter_core (
  input  logic                               clk,
  input  logic                               rst,
  bpsb_in_if.sink                            pixels,
  bpsb_out_if.source                         writes,
  input  logic                               cfg_write,
  input  logic [bpsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpsb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bpsb_pkg::*;

  cfg_t    cfg;
  job_t    job;
  job_t    head;
  logic    job_push;
  logic    q_pop;
  q_stat_t q_stat;

  // Configuration registers, written one at a time by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_mode <= 1'b0;
      cfg.image_width <= '0;
      cfg.image_height <= '0;
      cfg.x_origin <= '0;
      cfg.y_origin <= '0;
      cfg.line_pitch <= DIM_W'(1);
      cfg.channel_shifts <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEPTH_MODE: cfg.depth_mode <= cfg_data[0];
        REG_IMAGE_WIDTH: cfg.image_width <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[HEIGHT_W-1:0];
        REG_X_ORIGIN: cfg.x_origin <= cfg_data[ORIGIN_W-1:0];
        REG_Y_ORIGIN: cfg.y_origin <= cfg_data[ORIGIN_W-1:0];
        REG_LINE_PITCH: cfg.line_pitch <= cfg_data[DIM_W-1:0];
        REG_CHANNEL_SHIFTS: cfg.channel_shifts <= cfg_data[SHIFTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte classification and pixel/row/column tracking.
  bpsb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (job)
  );

  // Finished pixels wait here so that the front end need not stall on the output.
  bpsb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Address and data computation into the output register.
  bpsb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (!q_stat.empty),
    .pop        (q_pop),
    .writes     (writes)
  );

  // The front end must never complete a pixel into a full queue.
  `BPSB_ASSERT(a_no_push_when_full, job_push |-> !q_stat.full)
  // The write pipeline only reads the queue when it holds a pixel.
  `BPSB_ASSERT(a_no_pop_when_empty, q_pop |-> !q_stat.empty)
  // Reset leaves no write beat on the output.
  `BPSB_ASSERT_ALWAYS(a_reset_clears_output, rst |=> !writes.valid)

endmodule
`default_nettype wire

[test/bpsb_blit_checker.sv]
// Checker for the BMP pixel stream blitter: shadows the register writes, predicts every
// framebuffer write from the accepted pixel bytes and compares it with the write channel.
// Depends on bpsb_pkg and the channel interfaces in bpsb_stream_if.
`timescale 1ns / 1ps

module bpsb_blit_checker (
  input  logic                            clk,
  input  logic                            rst,
  bpsb_in_if                              pixels,
  bpsb_out_if                             writes,
  input  logic                            cfg_write,
  input  logic [bpsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpsb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              writes_outstanding
);
  import bpsb_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] data;
    logic              final_write;
  } fb_write_t;

  fb_write_t writes_due[$];
  cfg_t      regs;
  int        write_number;

  // Shadow of the block's byte-level state.
  logic [1:0]       byte_idx;
  logic [23:0]      partial_pixel;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic [1:0]       pad_bytes;
  logic             idle;

  assign writes_outstanding = writes_due.size();

  function automatic logic [DIM_W-1:0] clipped_width(input cfg_t c);
    return (c.image_width > DIM_W'(MaxImageDim)) ? DIM_W'(MaxImageDim) : c.image_width;
  endfunction

  function automatic logic [DIM_W-1:0] clipped_height(input cfg_t c);
    logic [HEIGHT_W-1:0] mag;
    mag = c.image_height[HEIGHT_W-1] ? (HEIGHT_W'(0) - c.image_height) : c.image_height;
    return (mag > HEIGHT_W'(MaxImageDim)) ? DIM_W'(MaxImageDim) : mag[DIM_W-1:0];
  endfunction

  // Bytes needed to bring a 24-bit row up to a multiple of four.
  function automatic logic [1:0] row_pad(input logic [DIM_W-1:0] w);
    logic [1:0] used;
    used = 2'(w * 3);
    return 2'd0 - used;
  endfunction

  function automatic logic [WORD_W-1:0] shifted_channel(input logic [7:0] v,
                                                        input logic [4:0] sh);
    logic [63:0] wide;
    wide = 64'(v) << sh;
    return wide[WORD_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic blit_byte(input logic [PIXEL_W-1:0] b, input logic start);
    logic [1:0]        last_idx;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [7:0]        red;
    logic [7:0]        alpha;
    logic [ADDR_W-1:0] y;
    logic [63:0]       linear;
    logic [COL_W:0]    next_col;
    logic [ROW_W:0]    next_row;
    fb_write_t         beat;
    last_idx = regs.depth_mode ? 2'd3 : 2'd2;
    w = clipped_width(regs);
    h = clipped_height(regs);
    if (start) begin
      byte_idx = '0;
      partial_pixel = '0;
      column = '0;
      row = '0;
      pad_bytes = '0;
      idle = (w == 0) || (h == 0);
    end
    if (idle) begin
      // Nothing to do until the next start byte.
    end else if (pad_bytes != 0) begin
      pad_bytes = pad_bytes - 2'd1;
    end else if (byte_idx < last_idx) begin
      partial_pixel[byte_idx*8 +: 8] = b;
      byte_idx = byte_idx + 2'd1;
    end else begin
      red = regs.depth_mode ? partial_pixel[23:16] : b;
      alpha = regs.depth_mode ? b : 8'h00;
      byte_idx = '0;
      beat.data = shifted_channel(alpha, regs.channel_shifts[19:15])
                | shifted_channel(red, regs.channel_shifts[14:10])
                | shifted_channel(partial_pixel[15:8], regs.channel_shifts[9:5])
                | shifted_channel(partial_pixel[7:0], regs.channel_shifts[4:0]);
      if (regs.image_height[HEIGHT_W-1])
        y = ADDR_W'(regs.y_origin) + ADDR_W'(row);
      else
        y = ADDR_W'(regs.y_origin) + ADDR_W'(h) - ADDR_W'(1) - ADDR_W'(row);
      linear = 64'(y) * 64'(regs.line_pitch) + 64'(regs.x_origin) + 64'(column);
      beat.address = linear[ADDR_W-1:0];
      beat.final_write = 1'b0;
      next_col = {1'b0, column} + (COL_W+1)'(1);
      if (next_col >= w) begin
        column = '0;
        next_row = {1'b0, row} + (ROW_W+1)'(1);
        if (next_row >= {1'b0, h}) begin
          beat.final_write = 1'b1;
          idle = 1'b1;
        end else begin
          pad_bytes = regs.depth_mode ? 2'd0 : row_pad(w);
        end
        row = next_row[ROW_W-1:0];
      end else begin
        column = next_col[COL_W-1:0];
      end
      writes_due.push_back(beat);
    end
  endtask

  task automatic check_write();
    fb_write_t want;
    write_number++;
    if (writes_due.size() == 0) begin
      note_failure($sformatf("write %0d not expected: address %h data %h final %b",
                             write_number, writes.write_address, writes.write_data,
                             writes.final_write));
    end else begin
      want = writes_due.pop_front();
      if (writes.write_address !== want.address)
        note_failure($sformatf("write %0d address: expected %h, got %h",
                               write_number, want.address, writes.write_address));
      if (writes.write_data !== want.data)
        note_failure($sformatf("write %0d data: expected %h, got %h",
                               write_number, want.data, writes.write_data));
      if (writes.final_write !== want.final_write)
        note_failure($sformatf("write %0d final_write: expected %b, got %b",
                               write_number, want.final_write, writes.final_write));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs <= '{depth_mode: 1'b0, image_width: '0, image_height: '0, x_origin: '0,
                y_origin: '0, line_pitch: DIM_W'(1), channel_shifts: '0};
      byte_idx = '0;
      partial_pixel = '0;
      column = '0;
      row = '0;
      pad_bytes = '0;
      idle = 1'b1;
      fail_count = 0;
      write_number = 0;
      writes_due.delete();
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_DEPTH_MODE:     regs.depth_mode <= cfg_data[0];
          REG_IMAGE_WIDTH:    regs.image_width <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:   regs.image_height <= cfg_data[HEIGHT_W-1:0];
          REG_X_ORIGIN:       regs.x_origin <= cfg_data[ORIGIN_W-1:0];
          REG_Y_ORIGIN:       regs.y_origin <= cfg_data[ORIGIN_W-1:0];
          REG_LINE_PITCH:     regs.line_pitch <= cfg_data[DIM_W-1:0];
          REG_CHANNEL_SHIFTS: regs.channel_shifts <= cfg_data[SHIFTS_W-1:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) blit_byte(pixels.pixel_byte, pixels.image_start);
      if (writes.valid && writes.ready) check_write();
    end
  end

endmodule

[test/tb_top.sv]
// Top of the BMP pixel stream blitter testbench: clock, reset, register programming,
// pixel byte stimulus and write-side backpressure, plus the final verdict.
// Depends on bpsb_pkg, bpsb_stream_if, bpsb_blit_checker and the blitter RTL.
`timescale 1ns / 1ps

module tb_top;
  import bpsb_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    writes_outstanding;

  // The register values the stimulus believes are programmed.
  cfg_t settings;
  // When set, neither side inserts gaps, giving stretches at full rate.
  bit   steady;
  int   stall_left;
  // Bytes sent as part of proper images; this is what bounds the random section.
  int   image_bytes;

  bpsb_in_if  pixels_ch ();
  bpsb_out_if writes_ch ();

  bmp_pixel_stream_blitter_core DUT (
    .clk,
    .rst,
    .pixels    (pixels_ch),
    .writes    (writes_ch),
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  bpsb_blit_checker write_monitor (
    .clk,
    .rst,
    .pixels             (pixels_ch),
    .writes             (writes_ch),
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .fail_count,
    .writes_outstanding
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hard stop in case the block hangs or drops a write we are waiting for.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long pause.
  function automatic int gap_length();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Write-side backpressure. Ready changes only on the falling edge, so a stall can
  // land on any stage of the pipeline and on a full pixel queue.
  initial begin
    writes_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        writes_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        writes_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_length();
      end
    end
  end

  // Presents one byte and returns on the falling edge after it has been taken. Valid
  // stays high on return, so back-to-back bytes go out with no bubble.
  task automatic push_byte(input logic [PIXEL_W-1:0] b, input logic st);
    int idle_cycles;
    idle_cycles = gap_length();
    if (idle_cycles > 0) begin
      pixels_ch.valid <= 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    pixels_ch.valid <= 1'b1;
    pixels_ch.pixel_byte <= b;
    pixels_ch.image_start <= st;
    do @(posedge clk); while (!pixels_ch.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted write has come out. Bytes that make
  // no write (padding, ignored bytes) can still be in flight, so a few more cycles pass
  // before the registers may be touched.
  task automatic settle();
    pixels_ch.valid <= 1'b0;
    while (writes_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(input reg_index_t r);
    case (r)
      REG_DEPTH_MODE:     return CFG_DATA_W'(settings.depth_mode);
      REG_IMAGE_WIDTH:    return CFG_DATA_W'(settings.image_width);
      REG_IMAGE_HEIGHT:   return CFG_DATA_W'({settings.image_height});
      REG_X_ORIGIN:       return CFG_DATA_W'(settings.x_origin);
      REG_Y_ORIGIN:       return CFG_DATA_W'(settings.y_origin);
      REG_LINE_PITCH:     return CFG_DATA_W'(settings.line_pitch);
      REG_CHANNEL_SHIFTS: return CFG_DATA_W'(settings.channel_shifts);
      default:            return '0;
    endcase
  endfunction

  // Writes every register from the settings, one per cycle.
  task automatic program_regs();
    reg_index_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data <= reg_value(r);
      @(negedge clk);
      r = r.next();
    end
    cfg_write <= 1'b0;
  endtask

  // Waits for the block to go quiet, then loads a full register set.
  task automatic configure(input logic depth, input int w, input int h, input int x,
                           input int y, input int pitch, input logic [SHIFTS_W-1:0] shifts);
    settle();
    settings.depth_mode = depth;
    settings.image_width = DIM_W'(w);
    settings.image_height = HEIGHT_W'(h);
    settings.x_origin = ORIGIN_W'(x);
    settings.y_origin = ORIGIN_W'(y);
    settings.line_pitch = DIM_W'(pitch);
    settings.channel_shifts = shifts;
    program_regs();
  endtask

  // Random small image geometry; origins and shifts span their fields, pitch 1 to 4096.
  task automatic pick_settings();
    int mag;
    int pitch;
    mag = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
    case ($urandom_range(0, 7))
      0:       pitch = 1;
      1:       pitch = MaxImageDim;
      default: pitch = $urandom_range(1, MaxImageDim);
    endcase
    configure($urandom_range(0, 1),
              ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6),
              $urandom_range(0, 1) ? -mag : mag,
              $urandom_range(0, 4095), $urandom_range(0, 4095), pitch,
              SHIFTS_W'($urandom));
  endtask

  // Sends the pixel data of an image under the current settings: random pixel bytes,
  // row padding where 24-bit rows need it, and optionally the padding after the last
  // row, which the block must ignore. A nonzero pixel limit cuts the image short, and
  // the next start byte then has to clear the half-done state. An empty image gets a
  // start byte and two more bytes, all of which must be ignored.
  task automatic feed_image(input int pixel_limit, input bit trailing_pad);
    int   w;
    int   h;
    int   per_pixel;
    int   pad;
    int   sent_pixels;
    int   r;
    int   c;
    logic st;
    w = (settings.image_width > DIM_W'(MaxImageDim)) ? MaxImageDim
                                                     : int'(settings.image_width);
    h = int'(settings.image_height);
    if (h < 0) h = -h;
    if (h > MaxImageDim) h = MaxImageDim;
    per_pixel = settings.depth_mode ? 4 : 3;
    pad = settings.depth_mode ? 0 : (4 - (w * 3) % 4) % 4;
    st = 1'b1;
    sent_pixels = 0;
    if (w == 0 || h == 0) begin
      push_byte(8'($urandom), 1'b1);
      repeat (2) push_byte(8'($urandom), 1'b0);
    end else begin
      for (r = 0; r < h && (pixel_limit == 0 || sent_pixels < pixel_limit); r++) begin
        for (c = 0; c < w && (pixel_limit == 0 || sent_pixels < pixel_limit); c++) begin
          repeat (per_pixel) begin
            push_byte(8'($urandom), st);
            st = 1'b0;
            image_bytes++;
          end
          sent_pixels++;
        end
        if (c == w && (r < h - 1 || trailing_pad))
          repeat (pad) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    int choice;
    int waited;
    logic [SHIFTS_W-1:0] plain_shifts;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixels_ch.valid = 1'b0;
    pixels_ch.pixel_byte = '0;
    pixels_ch.image_start = 1'b0;
    steady = 1'b0;
    image_bytes = 0;
    settings = '{depth_mode: 1'b0, image_width: '0, image_height: '0, x_origin: '0,
                 y_origin: '0, line_pitch: DIM_W'(1), channel_shifts: '0};
    // Blue in the low byte, then green, red and alpha: the usual ARGB layout.
    plain_shifts = {5'd24, 5'd16, 5'd8, 5'd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: zero width and height, so the start byte and the rest are ignored.
    feed_image(0, 1'b0);

    // Single white 24-bit pixel; alpha must come out as zero.
    configure(1'b0, 1, 1, 0, 0, 1, plain_shifts);
    push_byte(8'hff, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);

    // Largest origins, pitch 4096 and every shift at 31, so most channel bits fall off
    // the top of the word; top-down single pixel in 32-bit mode.
    configure(1'b1, 1, -1, 4095, 4095, MaxImageDim, '1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);

    // Bottom-up 24-bit image one pixel wide: one padding byte per row, and one more
    // after the last row that the block has to drop.
    configure(1'b0, 1, 2, 7, 3, MaxImageDim, SHIFTS_W'($urandom));
    feed_image(0, 1'b1);

    // Depth switched from 24 to 32 bits after blue and green: the third byte becomes
    // red and the fourth finishes the pixel as alpha.
    configure(1'b0, 1, 1, 0, 0, 1, plain_shifts);
    push_byte(8'ha1, 1'b1);
    push_byte(8'hb2, 1'b0);
    configure(1'b1, 1, 1, 0, 0, 1, plain_shifts);
    push_byte(8'hc3, 1'b0);
    push_byte(8'hd4, 1'b0);

    // Depth switched from 32 to 24 bits with three bytes held: the next byte finishes
    // the pixel as red and alpha is zero.
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    configure(1'b0, 1, 1, 0, 0, 1, plain_shifts);
    push_byte(8'h44, 1'b0);

    // Height cut from three to one after the first row of a bottom-up image. The
    // second row then lies below the origin and wraps, and it ends the image.
    configure(1'b1, 1, 3, 0, 0, 5, plain_shifts);
    push_byte(8'($urandom), 1'b1);
    repeat (3) push_byte(8'($urandom), 1'b0);
    configure(1'b1, 1, 1, 0, 0, 5, plain_shifts);
    repeat (4) push_byte(8'($urandom), 1'b0);

    // Random section. Most of it is whole images with random settings and data, some
    // back to back with no reprogramming, some cut short; the rest is loose bytes
    // with the odd start flag among them.
    image_bytes = 0;
    while (image_bytes < 360) begin
      choice = $urandom_range(0, 9);
      if (choice < 2) begin
        repeat ($urandom_range(1, 8))
          push_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        if (choice < 7) pick_settings();
        steady = ($urandom_range(0, 4) == 0);
        feed_image(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(0, 1));
        steady = 1'b0;
      end
    end

    // Oversized width saturates to the largest image; only the first few pixels of
    // the first row go out, at full rate.
    configure(1'b0, 8191, 2, $urandom_range(0, 4095), $urandom_range(0, 4095),
              MaxImageDim, SHIFTS_W'($urandom));
    steady = 1'b1;
    feed_image(4, 1'b0);
    steady = 1'b0;

    // Oversized heights, both signs: the bottom-up rows start from the saturated height.
    configure(1'b1, 1, 8191, $urandom_range(0, 4095), 4095, MaxImageDim,
              SHIFTS_W'($urandom));
    feed_image(6, 1'b0);
    configure(1'b0, 3, -8192, 4095, 4095, MaxImageDim, SHIFTS_W'($urandom));
    feed_image(5, 1'b0);

    // Drain and give the pipeline time to show any write that should not be there.
    pixels_ch.valid <= 1'b0;
    waited = 0;
    while (writes_outstanding != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (writes_outstanding != 0)
      $display("%0d predicted writes never appeared", writes_outstanding);
    if (fail_count == 0 && writes_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
